@@ rtl/rmfd_pkg.sv @@
// Shared types, operation codes and byte helpers for the rotated mono
// frame buffer drawing engine. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rmfd_pkg;

  // Field widths of one request.
  localparam int FUNC_W  = 3;
  localparam int POS_W   = 10;
  localparam int SIZE_W  = 9;
  localparam int COUNT_W = 4;
  localparam int RADDR_W = 13;
  localparam int BYTE_W  = 8;

  // Signed width that holds every clipped or extended coordinate.
  localparam int COORD_W = 12;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [FUNC_W-1:0]         func_t;
  typedef logic [BYTE_W-1:0]         byte_t;

  // Operation codes.
  localparam func_t FUNC_CLEAR  = 3'd0;
  localparam func_t FUNC_PIXEL  = 3'd1;
  localparam func_t FUNC_FILL   = 3'd2;
  localparam func_t FUNC_BITMAP = 3'd3;
  localparam func_t FUNC_READ   = 3'd4;

  localparam byte_t BYTE_ONES = 8'hFF;
  localparam byte_t BYTE_ZERO = 8'h00;
  localparam logic [2:0] BIT_LAST = 3'd7;
  localparam logic [COUNT_W-1:0] BITMAP_MAX = 4'd8;

  // Bits lo..hi of a byte, counted from the MSB (source order).
  function automatic byte_t span_mask(input logic [2:0] lo, input logic [2:0] hi);
    byte_t head;
    byte_t tail;
    head = BYTE_ONES >> lo;
    tail = BYTE_ONES << (BIT_LAST - hi);
    return head & tail;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rotated_mono_framebuffer_draw.sv @@
// Top level of the rotated mono frame buffer drawing engine.
// Depends on rmfd_pkg and rmfd_ram.
//
// The engine draws on a landscape canvas PANEL_HEIGHT wide and PANEL_WIDTH
// high into a portrait 1-bit frame store held in one single-port-write RAM.
// A request is taken when start is high and busy is low. Every drawing
// operation is a read-modify-write of one store byte at a time (read in
// S_RD, written in S_WR): a single pixel touches one byte, a bitmap byte one
// per canvas column it covers (at most 8), a rectangle fill every store
// byte in its span (columns times bytes per column); a request wholly off
// the canvas leaves busy low. A clear writes one byte a cycle and keeps busy
// high over all PANEL_HEIGHT*ceil(PANEL_WIDTH/8) store bytes (4736 at
// default sizes). A read byte request gives read_data with a result_valid
// strobe, registered from the S_RBYTE state entered on acceptance, that
// lasts one cycle. The result must be captured in that cycle, as it is not
// held. The store content is undefined until the first clear.
`timescale 1ns / 1ps
`default_nettype none

module rotated_mono_framebuffer_draw
  import rmfd_pkg::*;
#(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 296
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [FUNC_W-1:0]         func,
  input  logic signed [POS_W-1:0]   x_pos,
  input  logic signed [POS_W-1:0]   y_pos,
  input  logic [SIZE_W-1:0]         rect_width,
  input  logic [SIZE_W-1:0]         rect_height,
  input  logic                      black_ink,
  input  logic [BYTE_W-1:0]         bitmap_byte,
  input  logic [COUNT_W-1:0]        bit_count,
  input  logic [RADDR_W-1:0]        read_address,
  output logic                      result_valid,
  output logic [BYTE_W-1:0]         read_data
);

  localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
  localparam int STORE_BYTES = PANEL_HEIGHT * ROW_BYTES;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int GATE_W      = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
  localparam int SRC_W       = $clog2(PANEL_WIDTH);

  localparam logic [ADDR_W-1:0] ROW_BYTES_A = ADDR_W'(ROW_BYTES);
  localparam logic [ADDR_W-1:0] CLR_LAST    = ADDR_W'(STORE_BYTES - 1);
  localparam coord_t LAND_W = coord_t'(PANEL_HEIGHT);
  localparam coord_t LAND_H = coord_t'(PANEL_WIDTH);
  localparam coord_t ONE_C  = coord_t'(1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_WR    = 3'd3;
  localparam logic [2:0] S_RBYTE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // Walker registers.
  logic [GATE_W-1:0] cx;
  logic [GATE_W-1:0] xlast;
  logic [SRC_W-1:0]  y0;
  logic [SRC_W-1:0]  ylast;
  logic [SRC_W-1:0]  bk;
  logic [ADDR_W-1:0] base;
  coord_t            xorig;
  logic [BYTE_W-1:0] bits;
  logic              is_bmp;
  logic              ink;

  // Byte being modified.
  logic [ADDR_W-1:0] wr_addr;
  byte_t             wr_mask;
  logic              wr_col_en;

  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_in_range;

  // Request decode and clipping.
  coord_t            xs, ys, x_ext, y_ext, x1, y1;
  coord_t            x0c, x1c, y0c, y1c, x1c_m1, y1c_m1, gate0;
  logic [COUNT_W-1:0] bmp_n;
  logic              nonempty;
  logic [ADDR_W-1:0] base0;

  // Walk control.
  logic [SRC_W-1:0]  bk_first;
  logic [SRC_W-1:0]  bk_last;
  logic              last_byte, last_col, walk_done;
  logic              accept;
  logic [ADDR_W-1:0] walk_addr;
  byte_t             mask;
  logic [2:0]        lo_bit, hi_bit;
  coord_t            cx_c, col_off;
  logic              col_en;

  // RAM ports.
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  byte_t             ram_wdata, ram_rdata, mod_data;

  // Clip the request to the canvas as it arrives.
  always_comb begin
    xs    = $signed({{(COORD_W-POS_W){x_pos[POS_W-1]}}, x_pos});
    ys    = $signed({{(COORD_W-POS_W){y_pos[POS_W-1]}}, y_pos});
    bmp_n = (bit_count > BITMAP_MAX) ? BITMAP_MAX : bit_count;
    if (func == FUNC_FILL) begin
      x_ext = $signed({{(COORD_W-SIZE_W){1'b0}}, rect_width});
      y_ext = $signed({{(COORD_W-SIZE_W){1'b0}}, rect_height});
    end else if (func == FUNC_BITMAP) begin
      x_ext = $signed({{(COORD_W-COUNT_W){1'b0}}, bmp_n});
      y_ext = ONE_C;
    end else begin
      x_ext = ONE_C;
      y_ext = ONE_C;
    end
    x1     = xs + x_ext;
    y1     = ys + y_ext;
    x0c    = (xs < 0) ? '0 : xs;
    y0c    = (ys < 0) ? '0 : ys;
    x1c    = (x1 > LAND_W) ? LAND_W : x1;
    y1c    = (y1 > LAND_H) ? LAND_H : y1;
    x1c_m1 = x1c - ONE_C;
    y1c_m1 = y1c - ONE_C;
    nonempty = (x0c < x1c) && (y0c < y1c);
    gate0  = LAND_W - ONE_C - x0c;
    base0  = ADDR_W'(gate0[GATE_W-1:0]) * ROW_BYTES_A;
  end

  // Position within the current column and the mask for the current byte.
  always_comb begin
    bk_first  = y0 >> 3;
    bk_last   = ylast >> 3;
    last_byte = (bk == bk_last);
    last_col  = (cx == xlast);
    walk_done = last_byte && last_col;
    walk_addr = base + ADDR_W'(bk);
    lo_bit    = (bk == bk_first) ? y0[2:0] : 3'd0;
    hi_bit    = last_byte ? ylast[2:0] : BIT_LAST;
    mask      = span_mask(lo_bit, hi_bit);
    cx_c      = $signed({{(COORD_W-GATE_W){1'b0}}, cx});
    col_off   = cx_c - xorig;
    col_en    = !is_bmp || bits[col_off[2:0]];
  end

  // Handshake and next state.
  always_comb begin
    busy   = (state != S_IDLE) && !((state == S_WR) && walk_done);
    accept = start && !busy;
    state_next = state;
    case (state)
      S_CLEAR: if (clr_addr == CLR_LAST) begin
        state_next = S_IDLE;
      end
      S_RD:    state_next = S_WR;
      S_WR:    state_next = walk_done ? S_IDLE : S_RD;
      S_RBYTE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    if (accept) begin
      case (func)
        FUNC_CLEAR:                          state_next = S_CLEAR;
        FUNC_PIXEL, FUNC_FILL, FUNC_BITMAP:  state_next = nonempty ? S_RD : S_IDLE;
        FUNC_READ:                           state_next = S_RBYTE;
        default:                             state_next = S_IDLE;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == S_RBYTE);
    end
  end

  // Walker and request payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      ink         <= black_ink;
      clr_addr    <= '0;
      rd_addr     <= ADDR_W'(read_address);
      rd_in_range <= 32'(read_address) < 32'(STORE_BYTES);
      cx          <= x0c[GATE_W-1:0];
      xlast       <= x1c_m1[GATE_W-1:0];
      y0          <= y0c[SRC_W-1:0];
      ylast       <= y1c_m1[SRC_W-1:0];
      bk          <= y0c[SRC_W-1:0] >> 3;
      base        <= base0;
      xorig       <= xs;
      bits        <= bitmap_byte;
      is_bmp      <= (func == FUNC_BITMAP);
    end else begin
      case (state)
        S_CLEAR: clr_addr <= clr_addr + ADDR_W'(1);
        S_RD: begin
          wr_addr   <= walk_addr;
          wr_mask   <= mask;
          wr_col_en <= col_en;
        end
        S_WR: if (!walk_done) begin
          if (last_byte) begin
            cx   <= cx + GATE_W'(1);
            base <= base - ROW_BYTES_A;
            bk   <= bk_first;
          end else begin
            bk <= bk + SRC_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Store port selection and byte modification.
  always_comb begin
    mod_data  = ink ? (ram_rdata & ~wr_mask) : (ram_rdata | wr_mask);
    ram_we    = (state == S_CLEAR) || ((state == S_WR) && wr_col_en);
    ram_waddr = (state == S_CLEAR) ? clr_addr : wr_addr;
    ram_wdata = (state == S_CLEAR) ? (ink ? BYTE_ZERO : BYTE_ONES) : mod_data;
    ram_re    = (state == S_RD) || (state == S_RBYTE);
    ram_raddr = (state == S_RBYTE) ? rd_addr : walk_addr;
    read_data = rd_in_range ? ram_rdata : BYTE_ZERO;
  end

  rmfd_ram #(
    .DATA_W (BYTE_W),
    .DEPTH  (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef SYNTH
  // A result only follows a read byte cycle.
  a_result_after_read: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == S_RBYTE))
    else $error("result strobe without a preceding store read");

  // A modify write always follows the read of the same byte.
  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    (ram_we && (state == S_WR)) |-> $past(state == S_RD))
    else $error("modify write without a preceding read");

  // The walker never leaves the clipped byte range of a column.
  a_byte_in_span: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> ((bk >= bk_first) && (bk <= bk_last) && (mask != BYTE_ZERO)))
    else $error("walker outside the clipped byte range");

  // No request may be taken while the store is being cleared.
  a_busy_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> busy)
    else $error("busy low during a clear sweep");
`endif

endmodule

`default_nettype wire

@@ rtl/rmfd_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rmfd_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4736
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [DATA_W-1:0]                          wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [DATA_W-1:0]                          rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; registered, and updated only when re is high.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
